FILE: hdl/tep_pkg.sv
package tep_pkg;

   typedef struct packed {
      logic [1:0]          command;
      logic signed [15:0]  finger_number;
      logic signed [23:0]  x_position;
      logic signed [23:0]  y_position;
      logic [47:0]         time_ms;
   } req_type;

   typedef struct packed {
      logic [63:0] packed_word;
      logic [5:0]  slot;
      logic [17:0] sequence_res;
   } rsp_type;

   typedef struct packed {
      logic [15:0] qx;
      logic [15:0] qy;
      logic [47:0] when_ms;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_ctrl_type;

   localparam logic [1:0]  CMD_DOWN    = 2'd0;
   localparam logic [1:0]  CMD_MOVE    = 2'd1;
   localparam logic [1:0]  CMD_UP      = 2'd2;
   localparam logic [1:0]  CMD_INVALID = 2'd3;

   localparam logic        REG_EPOCH  = 1'b0;
   localparam logic        REG_WINDOW = 1'b1;

   localparam logic [7:0]  EPOCH_RESET  = 8'd1;
   localparam logic [15:0] WINDOW_RESET = 16'd20;
   localparam logic [17:0] SEQ_MAX      = 18'h3FFFF;

   localparam logic [16:0] Q_ONE  = 17'd65536;
   localparam logic [16:0] Q_HALF = 17'd32768;

   // floor((c*65535+32768)/65536) over 0..1.0 is c, less one above one half
   function automatic logic [15:0] quantize(input logic signed [23:0] raw);
      logic [16:0] c;
      logic [16:0] q;
      if (raw < 0) begin
         c = 17'd0;
      end else if (raw > 24'sd65536) begin
         c = Q_ONE;
      end else begin
         c = raw[16:0];
      end
      q = (c > Q_HALF) ? c - 17'd1 : c;
      return q[15:0];
   endfunction

endpackage

FILE: hdl/tep_event_table.sv
module tep_event_table #(
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tep_pkg::tbl_ctrl_type    ctrl,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   input  logic [$clog2(DEPTH)-1:0] look_idx,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  tep_pkg::entry_type       wr_data,
   output tep_pkg::entry_type       entry
);

   localparam int IDX_W = $clog2(DEPTH);

   tep_pkg::entry_type mem [DEPTH];
   tep_pkg::entry_type rd_data_ff;
   logic [DEPTH-1:0]   valid_ff;
   logic               fwd_valid_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   tep_pkg::entry_type fwd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
         fwd_valid_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         fwd_idx_ff  <= wr_idx;
         fwd_data_ff <= wr_data;
      end
   end

   // last write bypasses the registered read, which may predate it
   always_comb begin
      if (!valid_ff[look_idx]) begin
         entry = '0;
      end else if (fwd_valid_ff && fwd_idx_ff == look_idx) begin
         entry = fwd_data_ff;
      end else begin
         entry = rd_data_ff;
      end
   end

endmodule

FILE: hdl/touch_event_packer_unit.sv
// Touch event packer.
// Input channel req_: one touch event per word (action, finger, x, y, time).
// Result channel rsp_: packed 64-bit notification word, slot and sequence.
// Both channels move a word when valid is high and stall is low.
// Action 3 and repeats of the last event of the same action and finger
// (same quantised position, within the window) give no result word.
// Throughput: one event per cycle while req_stall is low. Results are
// registered on rsp_ after the input register and the compare stage, the
// path being a 3*FINGER_COUNT entry last-event table read, then update.
// An output register parts the two sides, so a new event is taken while
// a result waits; req_stall rises only when a result is held by rsp_stall
// and the event in the compare stage would publish.
// csr_: APB-style port, epoch at 0x0, dedupe window in ms at 0x4.
// Reset (synchronous) clears the table valid bits at once, the sequence to
// zero, epoch to 1 and the window to 20; events are taken straight after.
module touch_event_packer_unit #(
   parameter int SLOT_COUNT   = 64,
   parameter int FINGER_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tep_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tep_pkg::rsp_type rsp_word,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int DEPTH = 3 * FINGER_COUNT;
   localparam int IDX_W = $clog2(DEPTH);

   logic [7:0]  epoch_ff;
   logic [15:0] window_ff;

   logic             a_valid_ff;
   logic [1:0]       a_cmd_ff;
   logic [3:0]       a_finger_ff;
   logic [15:0]      a_qx_ff;
   logic [15:0]      a_qy_ff;
   logic [47:0]      a_time_ff;
   logic [IDX_W-1:0] a_idx_ff;

   logic [17:0]      seq_ff;
   logic [17:0]      seq_in;
   logic [5:0]       slot_ff;
   logic [5:0]       slot_in;
   logic             rsp_valid_ff;
   tep_pkg::rsp_type rsp_word_ff;

   logic [3:0]            finger;
   logic [IDX_W-1:0]      idx;
   logic                  accept;
   tep_pkg::entry_type    entry;
   tep_pkg::entry_type    wr_data;
   tep_pkg::tbl_ctrl_type ctrl;
   logic [47:0]           age;
   logic                  repeat_hit;
   logic                  publish;
   logic                  out_free;
   logic                  a_advance;

   // configuration
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff  <= tep_pkg::EPOCH_RESET;
         window_ff <= tep_pkg::WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            tep_pkg::REG_EPOCH: begin
               epoch_ff <= (csr_pwdata[7:0] == 8'd0) ? 8'd1 : csr_pwdata[7:0];
            end
            tep_pkg::REG_WINDOW: begin
               window_ff <= csr_pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         tep_pkg::REG_EPOCH:  csr_prdata = {24'd0, epoch_ff};
         tep_pkg::REG_WINDOW: csr_prdata = {16'd0, window_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // input side: clamp finger, form table index
   always_comb begin
      if (req_word.finger_number < 0) begin
         finger = 4'd0;
      end else if (req_word.finger_number > 16'(FINGER_COUNT - 1)) begin
         finger = 4'(FINGER_COUNT - 1);
      end else begin
         finger = req_word.finger_number[3:0];
      end
      if (req_word.command == tep_pkg::CMD_INVALID) begin
         idx = '0;
      end else begin
         idx = IDX_W'(req_word.command) * IDX_W'(FINGER_COUNT) + IDX_W'(finger);
      end
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff    <= req_word.command;
         a_finger_ff <= finger;
         a_qx_ff     <= tep_pkg::quantize(req_word.x_position);
         a_qy_ff     <= tep_pkg::quantize(req_word.y_position);
         a_time_ff   <= req_word.time_ms;
         a_idx_ff    <= idx;
      end
   end

   // compare stage
   assign age = a_time_ff - entry.when_ms;
   assign repeat_hit = entry.qx == a_qx_ff && entry.qy == a_qy_ff &&
                       a_time_ff >= entry.when_ms && age <= {32'd0, window_ff};
   assign publish   = a_valid_ff && a_cmd_ff != tep_pkg::CMD_INVALID && !repeat_hit;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign a_advance = a_valid_ff && (out_free || !publish);
   assign req_stall = a_valid_ff && !a_advance;

   assign ctrl.rd_en = accept;
   assign ctrl.wr_en = publish && out_free;

   assign wr_data.qx      = a_qx_ff;
   assign wr_data.qy      = a_qy_ff;
   assign wr_data.when_ms = a_time_ff;

   tep_event_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .rd_idx   (idx),
      .look_idx (a_idx_ff),
      .wr_idx   (a_idx_ff),
      .wr_data  (wr_data),
      .entry    (entry)
   );

   // sequence wraps to 1; slot follows it modulo SLOT_COUNT
   always_comb begin
      seq_in = (seq_ff == tep_pkg::SEQ_MAX) ? 18'd1 : seq_ff + 18'd1;
      if (seq_in == 18'd1) begin
         slot_in = 6'(1 % SLOT_COUNT);
      end else if (slot_ff == 6'(SLOT_COUNT - 1)) begin
         slot_in = 6'd0;
      end else begin
         slot_in = slot_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 18'd0;
         slot_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         seq_ff       <= seq_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         rsp_word_ff.packed_word  <= {epoch_ff, seq_in, a_qy_ff, a_qx_ff,
                                      a_finger_ff, a_cmd_ff};
         rsp_word_ff.slot         <= slot_in;
         rsp_word_ff.sequence_res <= seq_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: hdl/tep_checker.sv
module tep_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tep_pkg::rsp_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_seq_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.sequence_res != 18'd0 &&
                    rsp_word.packed_word[55:38] == rsp_word.sequence_res)
      else $error("sequence field mismatch");

   a_action_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.packed_word[1:0] != tep_pkg::CMD_INVALID &&
                    rsp_word.packed_word[63:56] != 8'd0)
      else $error("dropped action or zero epoch in result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind touch_event_packer_unit tep_checker u_tep_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
